// ----- sv/uerc_pkg.sv -----
// types and constants shared by the ultrasonic echo range check unit
`timescale 1ns / 1ps

package uerc_pkg;

    localparam int PULSE_W = 16;
    localparam int DIST_W  = 15;
    localparam int OUT_W   = 16;
    localparam int PCT_W   = 10;
    localparam int ERR_W   = 8;
    localparam int STAT_W  = 2;
    localparam int PROD_W  = 32;
    localparam int NUM_W   = 25;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 2;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(PULSE_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PCT_W - 1);

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ERROR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd3;

    localparam logic [IDX_W-1:0] CFG_MIN_DIST = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_DIST = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_ERR  = 2'd2;

    localparam logic [DIST_W-1:0] MIN_DIST_RST = 15'd32;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 15'd6400;
    localparam logic [ERR_W-1:0]  MAX_ERR_RST  = 8'd5;

    localparam logic [OUT_W-1:0]  DIST_TIMEOUT = 16'hFFF0;
    localparam logic [ERR_W-1:0]  ERR_SAT      = 8'hFF;
    localparam logic [PROD_W:0]   ROUND_HALF   = 33'd32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_SCALE,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_TIMEOUT,
        K_MEAS
    } t_kind;

endpackage

// ----- sv/ultrasonic_echo_range_check_unit.sv -----
// ultrasonic echo range check: echo width to distance, range check and error count
//
// usage: an input transfer carries a request type and an echo width in microseconds.
// a width of zero is a timeout; request type one clears the error count. every input
// transfer gives exactly one output transfer with distance, percent, status and count.
// the width is multiplied bit-serially by the speed scale, one multiplier bit a cycle,
// then clamped and checked; an in-range item in a non-empty range then runs a
// restoring divider that yields one percent bit a cycle.
// a clear or a timeout goes straight to the output load; other items skip the divider
// when they are out of range or when the range is empty.
// one item is worked on at a time; o_in_stall is high from the input transfer
// until the result is loaded into the output register, so a new input transfer is
// not taken before the last item is through.
// the output register holds its result while i_out_stall is high; a finished item
// waits until the register is free, and the next input transfer is taken meanwhile
// only after that load. reset clears the error count, status, distance and percent,
// loads the default range and error limit, and drops o_out_valid. configuration writes
// are always ready; the user must make them while the unit is idle, as it does not enforce it.
`timescale 1ns / 1ps

module ultrasonic_echo_range_check_unit #(
    parameter int PULSE_BITS  = 16,
    parameter int SPEED_SCALE = 17983
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [uerc_pkg::PULSE_W-1:0]        i_pulse_us,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [uerc_pkg::OUT_W-1:0]   o_distance_q4,
    output logic [uerc_pkg::PCT_W-1:0]          o_percent_tenths,
    output logic [uerc_pkg::STAT_W-1:0]         o_status,
    output logic [uerc_pkg::ERR_W-1:0]          o_error_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uerc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [uerc_pkg::DIST_W-1:0]         i_cfg_data
);
    import uerc_pkg::*;

    localparam logic [PULSE_W-1:0] PULSE_MASK = (PULSE_BITS >= PULSE_W) ? {PULSE_W{1'b1}}
                                              : PULSE_W'((64'd1 << PULSE_BITS) - 64'd1);
    localparam logic [PROD_W-1:0]  SCALE_W    = PROD_W'(SPEED_SCALE);

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    logic [DIST_W-1:0]  r_min_dist, n_min_dist;
    logic [DIST_W-1:0]  r_max_dist, n_max_dist;
    logic [ERR_W-1:0]   r_max_err, n_max_err;

    logic [ERR_W-1:0]   r_err_cnt, n_err_cnt;
    logic [STAT_W-1:0]  r_last_stat, n_last_stat;
    logic [OUT_W-1:0]   r_last_dist, n_last_dist;
    logic [PCT_W-1:0]   r_last_pct, n_last_pct;
    logic               r_out_valid, n_out_valid;

    logic [PULSE_W-1:0] r_mult, n_mult;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic               r_in_range, n_in_range;
    logic [DIST_W-1:0]  r_den, n_den;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [NUM_W-1:0]   r_dsh, n_dsh;
    logic [PCT_W-1:0]   r_quo, n_quo;

    logic [PULSE_W-1:0] pulse_m;
    logic [PROD_W:0]    rnd_sum;
    logic [DIST_W-1:0]  raw;
    logic [DIST_W-1:0]  ofs;
    logic [ERR_W-1:0]   err_inc;
    logic               div_ge;

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_distance_q4    = r_last_dist;
    assign o_percent_tenths = r_last_pct;
    assign o_status         = r_last_stat;
    assign o_error_count    = r_err_cnt;
    assign o_cfg_ready      = 1'b1;

    assign pulse_m = i_pulse_us & PULSE_MASK;
    assign rnd_sum = {1'b0, r_prod} + ROUND_HALF;
    assign raw     = (rnd_sum[PROD_W:PROD_W-1] != 2'b00) ? {DIST_W{1'b1}}
                                                         : rnd_sum[PROD_W-2:PROD_W-1-DIST_W];
    assign ofs     = r_dist - r_min_dist;
    assign err_inc = (r_err_cnt == ERR_SAT) ? ERR_SAT : r_err_cnt + ERR_W'(1);
    assign div_ge  = (r_num >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_dist  <= MIN_DIST_RST;
            r_max_dist  <= MAX_DIST_RST;
            r_max_err   <= MAX_ERR_RST;
            r_err_cnt   <= '0;
            r_last_stat <= ST_OK;
            r_last_dist <= '0;
            r_last_pct  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_min_dist  <= n_min_dist;
            r_max_dist  <= n_max_dist;
            r_max_err   <= n_max_err;
            r_err_cnt   <= n_err_cnt;
            r_last_stat <= n_last_stat;
            r_last_dist <= n_last_dist;
            r_last_pct  <= n_last_pct;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_mult     <= n_mult;
        r_prod     <= n_prod;
        r_cnt      <= n_cnt;
        r_dist     <= n_dist;
        r_in_range <= n_in_range;
        r_den      <= n_den;
        r_num      <= n_num;
        r_dsh      <= n_dsh;
        r_quo      <= n_quo;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_min_dist  = r_min_dist;
        n_max_dist  = r_max_dist;
        n_max_err   = r_max_err;
        n_err_cnt   = r_err_cnt;
        n_last_stat = r_last_stat;
        n_last_dist = r_last_dist;
        n_last_pct  = r_last_pct;
        n_out_valid = r_out_valid;
        n_mult      = r_mult;
        n_prod      = r_prod;
        n_cnt       = r_cnt;
        n_dist      = r_dist;
        n_in_range  = r_in_range;
        n_den       = r_den;
        n_num       = r_num;
        n_dsh       = r_dsh;
        n_quo       = r_quo;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_DIST: n_min_dist = i_cfg_data;
                CFG_MAX_DIST: n_max_dist = i_cfg_data;
                CFG_MAX_ERR:  n_max_err  = i_cfg_data[ERR_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mult = pulse_m;
                    n_prod = '0;
                    n_cnt  = MUL_LAST;
                    if (i_req_type) begin
                        n_kind  = K_CLEAR;
                        n_state = S_DONE;
                    end else if (pulse_m == '0) begin
                        n_kind  = K_TIMEOUT;
                        n_state = S_DONE;
                    end else begin
                        n_kind  = K_MEAS;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod = {r_prod[PROD_W-2:0], 1'b0} + (r_mult[PULSE_W-1] ? SCALE_W : '0);
                n_mult = {r_mult[PULSE_W-2:0], 1'b0};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_in_range = (raw >= r_min_dist) && (raw <= r_max_dist);
                if (raw < r_min_dist) begin
                    n_dist = r_min_dist;
                end else if (raw > r_max_dist) begin
                    n_dist = r_max_dist;
                end else begin
                    n_dist = raw;
                end
                n_den = r_max_dist - r_min_dist;
                n_quo = '0;
                if ((raw >= r_min_dist) && (raw <= r_max_dist) && (r_max_dist > r_min_dist)) begin
                    n_state = S_SCALE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCALE: begin
                // times 1000 as 1024 - 16 - 8
                n_num   = (NUM_W'(ofs) << 10) - (NUM_W'(ofs) << 4) - (NUM_W'(ofs) << 3);
                n_dsh   = NUM_W'(r_den) << (PCT_W - 1);
                n_cnt   = DIV_LAST;
                n_quo   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_ge) begin
                    n_num = r_num - r_dsh;
                end
                n_quo = {r_quo[PCT_W-2:0], div_ge};
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_kind)
                        K_CLEAR: begin
                            n_err_cnt = '0;
                            if (r_last_stat == ST_ERROR) begin
                                n_last_stat = ST_OK;
                            end
                        end
                        K_TIMEOUT: begin
                            n_last_stat = ST_TIMEOUT;
                            n_last_dist = DIST_TIMEOUT;
                            n_last_pct  = '0;
                            n_err_cnt   = err_inc;
                        end
                        K_MEAS: begin
                            n_last_dist = {1'b0, r_dist};
                            if (r_in_range) begin
                                n_last_stat = ST_OK;
                                n_last_pct  = r_quo;
                                n_err_cnt   = '0;
                            end else begin
                                n_last_pct  = '0;
                                n_err_cnt   = err_inc;
                                n_last_stat = (err_inc >= r_max_err) ? ST_ERROR : ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_timeout_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_TIMEOUT) |-> (o_distance_q4 == DIST_TIMEOUT))
        else $error("timeout status without timeout distance");

    a_err_pct_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_percent_tenths == '0))
        else $error("non-zero percent with error status");

    a_ok_no_errors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> (o_error_count == '0))
        else $error("ok status with non-zero error count");

    a_pct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_percent_tenths <= PCT_W'(1000))
        else $error("percent above full scale");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_MUL || r_state == S_CHK))
        else $error("multiplier left early");

endmodule

// ----- bench/tb_ultrasonic_echo_range_check_unit.sv -----
// self-checking testbench for the ultrasonic echo range check unit
`timescale 1ns / 1ps

module tb_ultrasonic_echo_range_check_unit;
    import uerc_pkg::*;

    localparam int          ECHO_PULSE_BITS = 16;
    localparam int unsigned ECHO_SCALE      = 17983;
    localparam int unsigned PCT_FULL        = 1000;
    localparam int unsigned RAW_SAT         = 32767;
    localparam int          SETTLE_CYCLES   = 40;
    localparam int          LONG_HOLD       = 300;
    localparam logic        REQ_MEAS        = 1'b0;
    localparam logic        REQ_CLEAR       = 1'b1;

    typedef struct packed {
        logic signed [OUT_W-1:0] distance;
        logic [PCT_W-1:0]        percent;
        logic [STAT_W-1:0]       status;
        logic [ERR_W-1:0]        err_count;
    } t_echo_result;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     req_type = REQ_MEAS;
    logic [PULSE_W-1:0]       pulse_us = '0;
    logic                     out_stall = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [IDX_W-1:0]         cfg_index = CFG_MIN_DIST;
    logic [DIST_W-1:0]        cfg_data = '0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [OUT_W-1:0]  distance_q4;
    logic [PCT_W-1:0]         percent_tenths;
    logic [STAT_W-1:0]        status;
    logic [ERR_W-1:0]         res_err_cnt;
    logic                     cfg_ready;

    // mirror of the unit's registers and state
    logic [DIST_W-1:0] cfg_min_dist  = MIN_DIST_RST;
    logic [DIST_W-1:0] cfg_max_dist  = MAX_DIST_RST;
    logic [ERR_W-1:0]  cfg_err_limit = MAX_ERR_RST;
    logic [ERR_W-1:0]  err_run       = '0;
    logic [STAT_W-1:0] held_status   = ST_OK;
    logic [OUT_W-1:0]  held_distance = '0;
    logic [PCT_W-1:0]  held_percent  = '0;

    t_echo_result expected_results[$];
    int           fail_count = 0;
    bit           gaps_on = 1'b1;
    int           hold_asked = 0;
    int           hold_served = 0;
    int unsigned  hold_left = 0;
    int unsigned  stall_left = 0;

    ultrasonic_echo_range_check_unit #(
        .PULSE_BITS  (ECHO_PULSE_BITS),
        .SPEED_SCALE (ECHO_SCALE)
    ) uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_pulse_us       (pulse_us),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_distance_q4    (distance_q4),
        .o_percent_tenths (percent_tenths),
        .o_status         (status),
        .o_error_count    (res_err_cnt),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [ERR_W-1:0] sat_bump(input logic [ERR_W-1:0] count);
        return (count == ERR_SAT) ? ERR_SAT : count + 1'b1;
    endfunction

    function automatic t_echo_result predict_echo(input logic req,
                                                  input logic [PULSE_W-1:0] pulse);
        logic [PROD_W:0]   scaled;
        logic [OUT_W-1:0]  raw;
        logic [OUT_W-1:0]  clamp_q4;
        int unsigned       span;
        t_echo_result      res;
        if (req == REQ_CLEAR) begin
            err_run = '0;
            if (held_status == ST_ERROR) held_status = ST_OK;
        end else if (pulse == '0) begin
            held_status   = ST_TIMEOUT;
            held_distance = DIST_TIMEOUT;
            held_percent  = '0;
            err_run       = sat_bump(err_run);
        end else begin
            scaled = (PROD_W+1)'(pulse) * (PROD_W+1)'(ECHO_SCALE) + ROUND_HALF;
            raw = (scaled[PROD_W:16] > RAW_SAT) ? OUT_W'(RAW_SAT) : scaled[31:16];
            if (raw < cfg_min_dist) clamp_q4 = OUT_W'(cfg_min_dist);
            else if (raw > cfg_max_dist) clamp_q4 = OUT_W'(cfg_max_dist);
            else clamp_q4 = raw;
            held_distance = clamp_q4;
            if (raw >= cfg_min_dist && raw <= cfg_max_dist) begin
                held_status = ST_OK;
                err_run     = '0;
                if (cfg_max_dist <= cfg_min_dist) begin
                    held_percent = '0;
                end else begin
                    span = 32'(cfg_max_dist - cfg_min_dist);
                    held_percent = PCT_W'(((clamp_q4 - cfg_min_dist) * PCT_FULL) / span);
                end
            end else begin
                held_percent = '0;
                err_run      = sat_bump(err_run);
                held_status  = (err_run >= cfg_err_limit) ? ST_ERROR : ST_RANGE;
            end
        end
        res.distance  = held_distance;
        res.percent   = held_percent;
        res.status    = held_status;
        res.err_count = err_run;
        return res;
    endfunction

    // output side: random stall bursts, plus a long hold on request
    always @(posedge clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        t_echo_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none actual distance %0d",
                         $time, distance_q4);
            end else begin
                want = expected_results.pop_front();
                check_field("distance", longint'(want.distance), longint'(distance_q4));
                check_field("percent", longint'(want.percent), longint'(percent_tenths));
                check_field("status", longint'(want.status), longint'(status));
                check_field("err count", longint'(want.err_count), longint'(res_err_cnt));
            end
        end
    end

    task automatic send_item(input logic req, input logic [PULSE_W-1:0] pulse);
        int unsigned gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        pulse_us <= pulse;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(predict_echo(req, pulse));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0 || in_stall);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MIN_DIST: cfg_min_dist = data;
            CFG_MAX_DIST: cfg_max_dist = data;
            CFG_MAX_ERR:  cfg_err_limit = data[ERR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi,
                             input logic [ERR_W-1:0] limit);
        wait_idle();
        write_reg(CFG_MIN_DIST, lo);
        write_reg(CFG_MAX_DIST, hi);
        // upper data bits are don't-care for the error limit
        write_reg(CFG_MAX_ERR, {(DIST_W-ERR_W)'($urandom), limit});
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_echo_item(output logic req, output logic [PULSE_W-1:0] pulse);
        int unsigned roll;
        longint      target;
        longint      width;
        roll  = $urandom_range(0, 11);
        req   = REQ_MEAS;
        pulse = PULSE_W'($urandom);
        if (roll == 0) begin
            req = REQ_CLEAR;
        end else if (roll == 1) begin
            pulse = '0;
        end else if (roll >= 4) begin
            // aim at the range or just around its edges
            if (roll >= 8)
                target = longint'($urandom_range(cfg_min_dist, cfg_max_dist));
            else
                target = longint'($urandom_range(0, 128)) - 64
                         + ((roll % 2 == 0) ? cfg_min_dist : cfg_max_dist);
            if (target < 0) target = 0;
            if (target > ECHO_SCALE) target = ECHO_SCALE;
            width = (target * 65536) / ECHO_SCALE + $urandom_range(0, 2) - 1;
            if (width < 1) width = 1;
            if (width > 65535) width = 65535;
            pulse = PULSE_W'(width);
        end
    endtask

    task automatic test_reset_defaults();
        send_item(REQ_CLEAR, 16'hFFFF);
        send_item(REQ_MEAS, 16'd0);
        send_item(REQ_CLEAR, 16'h0000);
        send_item(REQ_MEAS, 16'd1);
        send_item(REQ_MEAS, 16'd116);
        send_item(REQ_MEAS, 16'd117);
        send_item(REQ_MEAS, 16'd1000);
        send_item(REQ_MEAS, 16'd23324);
        send_item(REQ_MEAS, 16'd23325);
        send_item(REQ_MEAS, 16'hFFFF);
    endtask

    task automatic test_full_range();
        configure(15'd0, 15'd32767, 8'd0);
        send_item(REQ_MEAS, 16'd1);
        send_item(REQ_MEAS, 16'hFFFF);
        send_item(REQ_MEAS, 16'd0);
        send_item(REQ_MEAS, 16'h8000);
    endtask

    task automatic test_empty_range();
        configure(15'd100, 15'd100, 8'd0);
        send_item(REQ_MEAS, 16'd364);
        send_item(REQ_MEAS, 16'd1);
        send_item(REQ_MEAS, 16'hAAAA);
        send_item(REQ_CLEAR, 16'h5555);
    endtask

    task automatic test_inverted_range();
        configure(15'd32767, 15'd0, 8'd3);
        send_item(REQ_MEAS, 16'd30000);
        send_item(REQ_MEAS, 16'h5555);
        send_item(REQ_MEAS, 16'd1);
        send_item(REQ_CLEAR, 16'hAAAA);
    endtask

    task automatic test_error_limit();
        configure(15'd2000, 15'd3000, 8'd2);
        send_item(REQ_MEAS, 16'd1);
        send_item(REQ_MEAS, 16'd1);
        send_item(REQ_MEAS, 16'd1);
        send_item(REQ_CLEAR, 16'd0);
        send_item(REQ_MEAS, 16'd0);
        send_item(REQ_MEAS, 16'd9000);
    endtask

    task automatic test_output_hold();
        logic               req;
        logic [PULSE_W-1:0] pulse;
        configure(MIN_DIST_RST, MAX_DIST_RST, MAX_ERR_RST);
        gaps_on = 1'b0;
        hold_asked++;
        repeat (8) begin
            pick_echo_item(req, pulse);
            send_item(req, pulse);
        end
        gaps_on = 1'b1;
    endtask

    // long runs of errors, enough to saturate the count
    task automatic test_error_runs();
        int unsigned roll;
        configure(15'd8000, 15'd9000, 8'($urandom_range(150, 255)));
        repeat (270) begin
            roll = $urandom_range(0, 2);
            if (roll == 0) send_item(REQ_MEAS, '0);
            else if (roll == 1) send_item(REQ_MEAS, PULSE_W'($urandom_range(1, 29000)));
            else send_item(REQ_MEAS, PULSE_W'($urandom_range(33000, 65535)));
        end
        send_item(REQ_CLEAR, PULSE_W'($urandom));
        send_item(REQ_MEAS, 16'd30500);
    endtask

    task automatic test_random_settings();
        logic               req;
        logic [PULSE_W-1:0] pulse;
        logic [DIST_W-1:0]  lo;
        logic [DIST_W-1:0]  hi;
        logic [ERR_W-1:0]   limit;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    lo = DIST_W'($urandom_range(0, 500));
                    hi = DIST_W'($urandom_range(3000, 18000));
                    limit = ERR_W'($urandom_range(1, 6));
                end
                1: begin
                    lo = '0;
                    hi = '1;
                    limit = '1;
                end
                2: begin
                    lo = DIST_W'($urandom_range(0, 17000));
                    hi = lo;
                    limit = '0;
                end
                3: begin
                    hi = DIST_W'($urandom_range(0, 16000));
                    lo = hi + DIST_W'($urandom_range(1, 2000));
                    limit = ERR_W'($urandom_range(0, 8));
                end
                default: begin
                    lo = DIST_W'($urandom);
                    hi = DIST_W'($urandom);
                    limit = ERR_W'($urandom);
                end
            endcase
            configure(lo, hi, limit);
            repeat (40) begin
                pick_echo_item(req, pulse);
                send_item(req, pulse);
            end
        end
    endtask

    task automatic test_quiet_tail();
        logic               req;
        logic [PULSE_W-1:0] pulse;
        configure(DIST_W'($urandom_range(0, 1000)), DIST_W'($urandom_range(2000, 17000)),
                  ERR_W'($urandom_range(1, 10)));
        gaps_on = 1'b0;
        repeat (60) begin
            pick_echo_item(req, pulse);
            send_item(req, pulse);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_full_range();
        test_empty_range();
        test_inverted_range();
        test_error_limit();
        test_output_hold();
        test_error_runs();
        test_random_settings();
        test_quiet_tail();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
